// ===== rtl/core/sfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the serial frame receiver
// Byte tags passed from the front end to the back end, the result record,
// register map codes and reset values.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;

  localparam int unsigned TAG_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  localparam logic [7:0] HEADER_RESET = 8'd85;
  localparam logic [7:0] LENGTH_RESET = 8'd14;

  // Register indexes, taken from paddr[2].
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  // What the back end has to do with a byte.
  typedef enum logic [2:0] {
    OP_ID_HIGH = 3'd0,
    OP_ID_LOW  = 3'd1,
    OP_DATA    = 3'd2,
    OP_COUNT   = 3'd3,
    OP_CHECK   = 3'd4
  } tag_op_t;

  typedef struct packed {
    tag_op_t    op;
    logic [7:0] data;
  } tag_t;

  typedef struct packed {
    logic [15:0] msg_id;
    logic [63:0] payload;
    logic [7:0]  frame_count;
    logic        checksum_ok;
  } result_t;

endpackage

// ===== rtl/core/sfr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_fifo: small register FIFO
// First-word-fall-through queue of DEPTH entries (a power of two, at least 2).
// ----------------------------------------------------------------------------
module sfr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/core/sfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_front: frame sync and byte classification
// Hunts for the header, checks the length byte and tags every frame byte
// with the action the back end must take.
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_valid,
  input  logic [7:0]    byte_data,
  input  logic [7:0]    header_byte,
  input  logic [7:0]    length_byte,
  output logic          tag_push,
  output sfr_pkg::tag_t tag
);

  typedef enum logic [5:0] {
    ST_HUNT    = 6'b000001,
    ST_LENGTH  = 6'b000010,
    ST_ID_HIGH = 6'b000100,
    ST_ID_LOW  = 6'b001000,
    ST_DATA    = 6'b010000,
    ST_CHECK   = 6'b100000
  } front_state_t;

  front_state_t                 state_r, state_nxt;
  logic [sfr_pkg::IDX_W-1:0]    idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    tag_push  = 1'b0;
    tag.op    = sfr_pkg::OP_DATA;
    tag.data  = byte_data;
    if (byte_valid) begin
      unique case (state_r)
        ST_LENGTH: begin
          state_nxt = (byte_data == length_byte) ? ST_ID_HIGH : ST_HUNT;
        end
        ST_ID_HIGH: begin
          tag_push  = 1'b1;
          tag.op    = sfr_pkg::OP_ID_HIGH;
          state_nxt = ST_ID_LOW;
        end
        ST_ID_LOW: begin
          tag_push  = 1'b1;
          tag.op    = sfr_pkg::OP_ID_LOW;
          idx_nxt   = '0;
          state_nxt = ST_DATA;
        end
        ST_DATA: begin
          tag_push = 1'b1;
          if (idx_r < sfr_pkg::IDX_W'(sfr_pkg::PAYLOAD_BYTES)) begin
            tag.op  = sfr_pkg::OP_DATA;
            idx_nxt = idx_r + sfr_pkg::IDX_W'(1);
          end else begin
            tag.op    = sfr_pkg::OP_COUNT;
            idx_nxt   = '0;
            state_nxt = ST_CHECK;
          end
        end
        ST_CHECK: begin
          tag_push  = 1'b1;
          tag.op    = sfr_pkg::OP_CHECK;
          idx_nxt   = '0;
          state_nxt = ST_HUNT;
        end
        default: begin
          state_nxt = (byte_data == header_byte) ? ST_LENGTH : ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== rtl/core/sfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_back: frame assembly and checksum
// Takes tagged bytes from the queue, builds id, payload and count, keeps the
// additive payload sum and emits one result per checksum byte.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tag_empty,
  input  sfr_pkg::tag_t    tag,
  output logic             tag_pop,
  input  logic             res_full,
  output logic             res_push,
  output sfr_pkg::result_t res
);

  logic [15:0] id_r, id_nxt;
  logic [63:0] payload_r, payload_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        is_check;

  // A checksum byte waits until the result queue has room.
  assign is_check = (tag.op == sfr_pkg::OP_CHECK);
  assign tag_pop  = !tag_empty && (!is_check || !res_full);
  assign res_push = tag_pop && is_check;

  assign res.msg_id      = id_r;
  assign res.payload     = payload_r;
  assign res.frame_count = count_r;
  assign res.checksum_ok = (tag.data == sum_r);

  always_comb begin
    id_nxt      = id_r;
    payload_nxt = payload_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    if (tag_pop) begin
      unique case (tag.op)
        sfr_pkg::OP_ID_HIGH: id_nxt = {tag.data, 8'h00};
        sfr_pkg::OP_ID_LOW:  id_nxt = {id_r[15:8], tag.data};
        sfr_pkg::OP_DATA: begin
          payload_nxt = {payload_r[55:0], tag.data};
          sum_nxt     = sum_r + tag.data;
        end
        sfr_pkg::OP_COUNT:   count_nxt = tag.data;
        sfr_pkg::OP_CHECK: begin
          payload_nxt = '0;
          sum_nxt     = '0;
        end
        default: begin
          sum_nxt = sum_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    payload_r <= payload_nxt;
    count_r   <= count_nxt;
  end

endmodule

// ===== rtl/core/serial_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver: byte deframer with additive checksum
// Finds header-framed messages in a byte stream and reports id, payload,
// count and checksum status for each frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per transfer on in_rx_byte, taken at a
//   clock edge where push is high and full is low.
//   Result channel: the oldest result is shown while empty is low and leaves
//   at an edge where pop is high. A frame is header, length byte, two id bytes
//   (high first), eight payload bytes, a count byte and a checksum byte.
//   Every complete frame gives one result; checksum_ok tells whether the
//   checksum byte equals the 8-bit sum of the payload bytes.
//   Configuration: APB-style write of header_byte at address 0 and of
//   length_byte at address 4; pready is always high, reads return the value.
// Timing:
//   One byte per cycle sustained while full is low. A checksum byte is first
//   tagged into the byte queue by the front end; the back end then moves its
//   result into the result queue once that queue has room.
// Reset:
//   rst_n low returns the deframer to header hunting, clears the sum and
//   both queues, and restores the register reset values.
// Stalls:
//   If the result queue is full, the back end holds the next checksum byte,
//   the byte queue fills and full rises; no transfer is ever dropped.
// ----------------------------------------------------------------------------
module serial_frame_receiver #(
  parameter int unsigned TAG_DEPTH = sfr_pkg::TAG_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = sfr_pkg::OUT_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input byte channel
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_rx_byte,
  // result channel
  output logic                        empty,
  input  logic                        pop,
  output logic [15:0]                 out_msg_id,
  output logic [63:0]                 out_payload,
  output logic [7:0]                  out_frame_count,
  output logic                        out_checksum_ok,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfr_pkg::PADDR_W-1:0] paddr,
  input  logic [sfr_pkg::PDATA_W-1:0] pwdata,
  output logic [sfr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  logic [7:0]       header_r, header_nxt;
  logic [7:0]       length_r, length_nxt;
  logic             reg_sel;
  logic             cfg_write;

  logic             byte_valid;
  logic             tag_push, tag_pop, tag_empty;
  sfr_pkg::tag_t    tag_in, tag_out;
  logic             res_push;
  logic             res_full;
  sfr_pkg::result_t res_in, res_out;

  // Register file. Address bit 2 selects the register.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {{(sfr_pkg::PDATA_W - 8){1'b0}},
                      (reg_sel == sfr_pkg::REG_LENGTH) ? length_r : header_r};

  always_comb begin
    header_nxt = header_r;
    length_nxt = length_r;
    if (cfg_write) begin
      unique case (reg_sel)
        sfr_pkg::REG_HEADER: header_nxt = pwdata[7:0];
        sfr_pkg::REG_LENGTH: length_nxt = pwdata[7:0];
        default:             header_nxt = header_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= sfr_pkg::HEADER_RESET;
      length_r <= sfr_pkg::LENGTH_RESET;
    end else begin
      header_r <= header_nxt;
      length_r <= length_nxt;
    end
  end

  // A byte transfer completes whenever the byte queue has room.
  assign byte_valid = push && !full;

  sfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_data   (in_rx_byte),
    .header_byte (header_r),
    .length_byte (length_r),
    .tag_push    (tag_push),
    .tag         (tag_in)
  );

  // Hunting and length bytes are absorbed by the front end; only frame bytes
  // enter the queue, so it fills only when the back end stalls.
  sfr_fifo #(
    .WIDTH ($bits(sfr_pkg::tag_t)),
    .DEPTH (TAG_DEPTH)
  ) u_tag_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tag_push),
    .din   (tag_in),
    .full  (full),
    .pop   (tag_pop),
    .dout  (tag_out),
    .empty (tag_empty)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_empty (tag_empty),
    .tag       (tag_out),
    .tag_pop   (tag_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  sfr_fifo #(
    .WIDTH ($bits(sfr_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign out_msg_id      = res_out.msg_id;
  assign out_payload     = res_out.payload;
  assign out_frame_count = res_out.frame_count;
  assign out_checksum_ok = res_out.checksum_ok;

endmodule

// ===== rtl/core/sfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker: port-level checks of the serial frame receiver
// Watches reset behavior, queue fill and the result channel over time.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] out_msg_id,
  input logic [63:0] out_payload,
  input logic [7:0]  out_frame_count,
  input logic        out_checksum_ok
);

  // Reset empties both queues.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");

  // The byte queue grows only by an input transfer.
  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    (!full && !push) |=> !full)
    else $error("full rose without an input transfer");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("waiting result vanished");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> ($stable(out_msg_id) && $stable(out_payload) &&
                          $stable(out_frame_count) && $stable(out_checksum_ok)))
    else $error("waiting result changed");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_msg_id      (out_msg_id),
  .out_payload     (out_payload),
  .out_frame_count (out_frame_count),
  .out_checksum_ok (out_checksum_ok)
);
